// ===== src/civd_pkg.sv =====
// ----------------------------------------------------------------------------
// civd_pkg
// Shared widths, calendar constants, stage payload types and helper functions
// for the day count to civil date pipeline.
// ----------------------------------------------------------------------------
package civd_pkg;

  localparam int DAY_BITS = 24;

  localparam int ERA_DAYS      = 146097;
  localparam int ERA_LAST_DAY  = 146096;
  localparam int MARCH_SHIFT   = 719468;
  localparam int DAYS_4Y       = 1460;
  localparam int DAYS_100Y     = 36524;
  localparam int DAYS_YEAR     = 365;
  localparam int WD_OFFSET     = 3;
  localparam int YEAR_OF_ERA   = 400;

  // biased day count stays non-negative and below 2**ZP_BITS
  localparam int ZP_BITS   = DAY_BITS + 1;
  localparam int QB_BITS   = ZP_BITS - 17;
  localparam int ERA_BITS  = QB_BITS + 1;
  localparam int ERA_BIAS  = (2 ** (DAY_BITS - 1)) / ERA_DAYS + 1;
  localparam longint unsigned Z_BIAS =
    longint'(MARCH_SHIFT) + longint'(ERA_BIAS) * longint'(ERA_DAYS);
  localparam longint unsigned ERA_RECIP = (64'd1 << ZP_BITS) / 64'd146097;

  localparam int YEAR_BITS = (ERA_BITS + 10 > 16) ? ERA_BITS + 10 : 16;

  localparam int DOE_BITS  = 18;
  localparam int DIV_SHIFT = 18;
  localparam int A1_BITS   = 8;
  localparam int A2_BITS   = 3;
  localparam int R365_BITS = 10;
  localparam int YOE_BITS  = 9;
  localparam int DOY_BITS  = 9;
  localparam int MP_BITS   = 4;

  localparam int R1460  = (2 ** DIV_SHIFT) / DAYS_4Y;
  localparam int R36524 = (2 ** DIV_SHIFT) / DAYS_100Y;
  localparam int R365   = (2 ** DIV_SHIFT) / DAYS_YEAR;

  // yoe / 100 for yoe below 400
  localparam int Q100_MUL   = 41;
  localparam int Q100_SHIFT = 12;

  localparam int M7_IN_BITS = ZP_BITS + 1;
  localparam int M7_CHUNKS  = (M7_IN_BITS + 2) / 3;

  localparam int MP_JANUARY = 10;

  typedef struct packed {
    logic [DOE_BITS-1:0] doe;
    logic [ERA_BITS-1:0] era;
    logic [2:0]          wd;
  } era_t;

  typedef struct packed {
    logic [DOY_BITS-1:0]  doy;
    logic [YEAR_BITS-1:0] year_base;
    logic [2:0]           wd;
  } yoe_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [2:0]  wd;
  } res_t;

  function automatic logic [2:0] mod7(input logic [M7_IN_BITS-1:0] x);
    logic [M7_CHUNKS*3-1:0] xp;
    logic [6:0]             s1;
    logic [3:0]             s2;
    logic [3:0]             s3;
    xp = (M7_CHUNKS*3)'(x);
    s1 = '0;
    for (int i = 0; i < M7_CHUNKS; i++) begin
      s1 = s1 + 7'(xp[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]) + 4'(s1[6]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
  endfunction

  // first day of each March-based month
  function automatic logic [DOY_BITS-1:0] month_start(input logic [MP_BITS-1:0] mp);
    logic [DOY_BITS-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/civd_era.sv =====
// ----------------------------------------------------------------------------
// civd_era
// Stages 1-4: bias the day count, split it into era and day of era by
// reciprocal multiply with one correction step, and derive the weekday.
// ----------------------------------------------------------------------------
module civd_era import civd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DAY_BITS-1:0] day_i,
  output logic                valid_o,
  output era_t                data_o
);

  logic [3:0] v_q;

  logic [ZP_BITS-1:0] zp1_q, zp2_q, zp3_q;
  logic [ZP_BITS-1:0] zp1_d;
  logic [QB_BITS-1:0] q2_q, q3_q;
  logic [QB_BITS-1:0] q2_d;
  logic [2:0]         wd2_q, wd3_q;
  logic [2:0]         wd2_d;
  logic [ZP_BITS-1:0] prod3_q, prod3_d;
  era_t               out_q, out_d;

  logic [ZP_BITS+QB_BITS-1:0] eprod;
  logic [ZP_BITS-1:0]         rem;
  logic                       fix;
  logic [QB_BITS-1:0]         q4;

  assign zp1_d = {day_i[DAY_BITS-1], day_i} + ZP_BITS'(Z_BIAS);

  assign eprod = (ZP_BITS+QB_BITS)'(zp1_q) * (ZP_BITS+QB_BITS)'(ERA_RECIP);
  assign q2_d  = eprod[ZP_BITS+QB_BITS-1:ZP_BITS];
  assign wd2_d = mod7(M7_IN_BITS'(zp1_q) + M7_IN_BITS'(WD_OFFSET));

  assign prod3_d = ZP_BITS'(q2_q) * ZP_BITS'(ERA_DAYS);

  always_comb begin
    rem = zp3_q - prod3_q;
    fix = (rem >= ZP_BITS'(ERA_DAYS));
    q4  = q3_q + QB_BITS'(fix);
    out_d.doe = fix ? DOE_BITS'(rem - ZP_BITS'(ERA_DAYS)) : DOE_BITS'(rem);
    out_d.era = ERA_BITS'(q4) - ERA_BITS'(ERA_BIAS);
    out_d.wd  = wd3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zp1_q   <= zp1_d;
      zp2_q   <= zp1_q;
      q2_q    <= q2_d;
      wd2_q   <= wd2_d;
      zp3_q   <= zp2_q;
      q3_q    <= q2_q;
      wd3_q   <= wd2_q;
      prod3_q <= prod3_d;
      out_q   <= out_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = out_q;

endmodule

// ===== src/civd_yoe.sv =====
// ----------------------------------------------------------------------------
// civd_yoe
// Stages 5-10: year of era from day of era, then day of the March-based
// year and the year before the January/February adjustment.
// ----------------------------------------------------------------------------
module civd_yoe import civd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  era_t data_i,
  output logic valid_o,
  output yoe_t data_o
);

  logic [5:0] v_q;

  logic [DOE_BITS-1:0]  doe5_q, doe6_q, doe7_q, doe8_q, doe9_q;
  logic [YEAR_BITS-1:0] y5_q, y6_q, y7_q, y8_q, y9_q;
  logic [2:0]           wd5_q, wd6_q, wd7_q, wd8_q, wd9_q;
  logic [A1_BITS-1:0]   a1e_q, a1_q, a1_d;
  logic [A2_BITS-1:0]   a2e_q, a2_q, a2_d;
  logic                 b_q, b_d;
  logic [DOE_BITS-1:0]  n7_q, n8_q, n7_d;
  logic [YOE_BITS-1:0]  ye_q, ye_d, yoe_q, yoe_d;
  yoe_t                 out_q, out_d;

  logic [DOE_BITS+A1_BITS-1:0]   p1;
  logic [DOE_BITS+A2_BITS-1:0]   p2;
  logic [YEAR_BITS-1:0]          yb;
  logic [YEAR_BITS-1:0]          era400_d;
  logic [DOE_BITS-1:0]           r1, r2, r9;
  logic [DOE_BITS+R365_BITS-1:0] p365;
  logic [15:0]                   p100;
  logic [1:0]                    q100;

  always_comb begin
    p1 = (DOE_BITS+A1_BITS)'(data_i.doe) * (DOE_BITS+A1_BITS)'(R1460);
    p2 = (DOE_BITS+A2_BITS)'(data_i.doe) * (DOE_BITS+A2_BITS)'(R36524);
    yb = {{(YEAR_BITS-ERA_BITS){data_i.era[ERA_BITS-1]}}, data_i.era};
    era400_d = YEAR_BITS'(yb * YEAR_BITS'(YEAR_OF_ERA));
  end

  always_comb begin
    r1   = doe5_q - DOE_BITS'(a1e_q) * DOE_BITS'(DAYS_4Y);
    r2   = doe5_q - DOE_BITS'(a2e_q) * DOE_BITS'(DAYS_100Y);
    a1_d = a1e_q + A1_BITS'(r1 >= DOE_BITS'(DAYS_4Y));
    a2_d = a2e_q + A2_BITS'(r2 >= DOE_BITS'(DAYS_100Y));
    b_d  = (doe5_q == DOE_BITS'(ERA_LAST_DAY));
  end

  assign n7_d = doe6_q - DOE_BITS'(a1_q) + DOE_BITS'(a2_q) - DOE_BITS'(b_q);

  assign p365 = (DOE_BITS+R365_BITS)'(n7_q) * (DOE_BITS+R365_BITS)'(R365);
  assign ye_d = p365[DIV_SHIFT+YOE_BITS-1:DIV_SHIFT];

  always_comb begin
    r9    = n8_q - DOE_BITS'(ye_q) * DOE_BITS'(DAYS_YEAR);
    yoe_d = ye_q + YOE_BITS'(r9 >= DOE_BITS'(DAYS_YEAR));
  end

  always_comb begin
    p100 = 16'(yoe_q) * 16'(Q100_MUL);
    q100 = p100[Q100_SHIFT+1:Q100_SHIFT];
    out_d.doy = DOY_BITS'(doe9_q - DOE_BITS'(yoe_q) * DOE_BITS'(DAYS_YEAR)
                          - DOE_BITS'(yoe_q[YOE_BITS-1:2]) + DOE_BITS'(q100));
    out_d.year_base = y9_q + YEAR_BITS'(yoe_q);
    out_d.wd = wd9_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      doe5_q <= data_i.doe;
      y5_q   <= era400_d;
      wd5_q  <= data_i.wd;
      a1e_q  <= p1[DIV_SHIFT+A1_BITS-1:DIV_SHIFT];
      a2e_q  <= p2[DIV_SHIFT+A2_BITS-1:DIV_SHIFT];

      doe6_q <= doe5_q;
      y6_q   <= y5_q;
      wd6_q  <= wd5_q;
      a1_q   <= a1_d;
      a2_q   <= a2_d;
      b_q    <= b_d;

      doe7_q <= doe6_q;
      y7_q   <= y6_q;
      wd7_q  <= wd6_q;
      n7_q   <= n7_d;

      doe8_q <= doe7_q;
      y8_q   <= y7_q;
      wd8_q  <= wd7_q;
      n8_q   <= n7_q;
      ye_q   <= ye_d;

      doe9_q <= doe8_q;
      y9_q   <= y8_q;
      wd9_q  <= wd8_q;
      yoe_q  <= yoe_d;

      out_q  <= out_d;
    end
  end

  assign valid_o = v_q[5];
  assign data_o  = out_q;

endmodule

// ===== src/civd_month.sv =====
// ----------------------------------------------------------------------------
// civd_month
// Stages 11-12: month of the March-based year by compare against month
// starts, then civil month, day of month and adjusted year.
// ----------------------------------------------------------------------------
module civd_month import civd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  yoe_t data_i,
  output logic valid_o,
  output res_t data_o
);

  logic [1:0] v_q;

  logic [MP_BITS-1:0]   mp_q, mp_d;
  logic [DOY_BITS-1:0]  doy_q;
  logic [YEAR_BITS-1:0] yb_q;
  logic [2:0]           wd_q;
  res_t                 out_q, out_d;

  logic                 jan_feb;
  logic [YEAR_BITS-1:0] year_full;

  always_comb begin
    mp_d = '0;
    for (int k = 1; k < 12; k++) begin
      mp_d = mp_d + MP_BITS'(data_i.doy >= month_start(MP_BITS'(k)));
    end
  end

  always_comb begin
    jan_feb   = (mp_q >= MP_BITS'(MP_JANUARY));
    year_full = yb_q + YEAR_BITS'(jan_feb);
    out_d.year  = year_full[15:0];
    out_d.month = jan_feb ? 4'(mp_q - MP_BITS'(9)) : 4'(mp_q + MP_BITS'(3));
    out_d.dom   = 5'(doy_q - month_start(mp_q) + DOY_BITS'(1));
    out_d.wd    = wd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mp_q  <= mp_d;
      doy_q <= data_i.doy;
      yb_q  <= data_i.year_base;
      wd_q  <= data_i.wd;
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[1];
  assign data_o  = out_q;

endmodule

// ===== src/civd_skid.sv =====
// ----------------------------------------------------------------------------
// civd_skid
// Output register with one skid entry; holds the pipeline while the skid
// entry is occupied.
// ----------------------------------------------------------------------------
module civd_skid import civd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pipe_valid_i,
  input  res_t pipe_data_i,
  output logic en_o,
  output logic out_valid_o,
  output res_t out_data_o,
  input  logic out_stall_i
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic incoming, out_free;

  assign en_o     = !skid_valid_q;
  assign incoming = pipe_valid_i && en_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (incoming) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (incoming) begin
      if (out_free) begin
        out_q <= pipe_data_i;
      end else begin
        skid_q <= pipe_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output transaction");

  a_held_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled output transaction dropped");

  a_overflow_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (incoming && out_valid_q && out_stall_i) |=> (skid_valid_q && $stable(out_q)))
    else $error("incoming transaction not parked in skid entry");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (!skid_valid_q && out_valid_q))
    else $error("skid entry not moved to output");

endmodule

// ===== src/days_to_civil_date.sv =====
// ----------------------------------------------------------------------------
// days_to_civil_date
// Converts a signed day count since 1970-01-01 into proleptic Gregorian
// year, month, day of month and weekday (0 is Sunday).
//
//   channel   signals                                     direction
//   input     in_valid_i, in_stall_o, day_number_i        in
//   output    out_valid_o, out_stall_i, year_o, month_o,  out
//             day_of_month_o, weekday_o
//
// One transaction per cycle while the skid entry is empty; from accept to output
// valid there are 12 pipeline stages, then the output register.
// Stage depth is set by the era split and the constant reciprocal multiplies.
// Reset clears only the valid bits of stages and output buffer.
// A stalled output parks one result in the skid entry, which then holds the
// pipeline until the output side takes a transaction.
// ----------------------------------------------------------------------------
module days_to_civil_date import civd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [DAY_BITS-1:0] day_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         year_o,
  output logic [3:0]          month_o,
  output logic [4:0]          day_of_month_o,
  output logic [2:0]          weekday_o
);

  logic en;
  logic era_valid, yoe_valid, res_valid;
  era_t era_data;
  yoe_t yoe_data;
  res_t res_data, out_data;

  assign in_stall_o = !en;

  civd_era u_era (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .day_i   (day_number_i),
    .valid_o (era_valid),
    .data_o  (era_data)
  );

  civd_yoe u_yoe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (era_valid),
    .data_i  (era_data),
    .valid_o (yoe_valid),
    .data_o  (yoe_data)
  );

  civd_month u_month (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (yoe_valid),
    .data_i  (yoe_data),
    .valid_o (res_valid),
    .data_o  (res_data)
  );

  civd_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_valid_i (res_valid),
    .pipe_data_i  (res_data),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data),
    .out_stall_i  (out_stall_i)
  );

  assign year_o         = out_data.year;
  assign month_o        = out_data.month;
  assign day_of_month_o = out_data.dom;
  assign weekday_o      = out_data.wd;

endmodule
